// ===== rtl/lfrd_pkg.sv =====
// lfrd_pkg: shared types and constants of the longest free run direction block
// used by the channel interfaces, the run tracker and the top level
// no dependencies
package lfrd_pkg;

  // fixed field widths of the transactions
  localparam int unsigned READING_W = 8;
  localparam int unsigned CENTRE_W  = 8;
  localparam int unsigned WEIGHT_W  = 9;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 8;

  // counting by tens for the forward band (count / 10)
  localparam int unsigned BAND_DIV   = 10;
  localparam int unsigned BAND_REM_W = 4;

  // direction codes on the result channel
  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_FWD   = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEAR_THRESHOLD = 1'b0,
    REG_SEEK_OCCUPIED  = 1'b1
  } reg_idx_e;

endpackage

// ===== rtl/lfrd_in_if.sv =====
// lfrd_in_if: sector reading channel, one reading per transaction
// depends on lfrd_pkg
interface lfrd_in_if;
  logic                              valid;
  logic                              ready;
  logic [lfrd_pkg::READING_W-1:0]    reading;
  logic                              last_sector;

  modport source (output valid, output reading, output last_sector, input ready);
  modport sink   (input valid, input reading, input last_sector, output ready);
endinterface

// ===== rtl/lfrd_out_if.sv =====
// lfrd_out_if: result channel, one transaction per finished scan
// depends on lfrd_pkg
interface lfrd_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        direction;
  logic [lfrd_pkg::CENTRE_W-1:0]     centre;
  logic [lfrd_pkg::WEIGHT_W-1:0]     run_weight;

  modport source (output valid, output direction, output centre, output run_weight,
                  input ready);
  modport sink   (input valid, input direction, input centre, input run_weight,
                  output ready);
endinterface

// ===== rtl/lfrd_cfg_if.sv =====
// lfrd_cfg_if: configuration write channel, register index plus write data
// depends on lfrd_pkg
interface lfrd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lfrd_pkg::CFG_IDX_W-1:0]    index;
  logic [lfrd_pkg::CFG_DAT_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/lfrd_tracker.sv =====
// lfrd_tracker: input register and run tracking over one scan
// hands the closed scan (count, band, best run) to the result stage
// depends on lfrd_pkg and lfrd_in_if
module lfrd_tracker #(
  parameter int unsigned MAX_SECTORS = 256,
  parameter int unsigned CW = $clog2(MAX_SECTORS + 1),
  parameter int unsigned SW = $clog2(MAX_SECTORS)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  lfrd_in_if.sink                           in_ch,
  input  logic [lfrd_pkg::READING_W-1:0]    near_threshold_i,
  input  logic                              seek_occupied_i,
  input  logic                              fin_take_i,
  output logic                              fin_valid_o,
  output logic [CW-1:0]                     fin_count_o,
  output logic [CW-1:0]                     fin_band_o,
  output logic [CW-1:0]                     fin_len_o,
  output logic [SW-1:0]                     fin_start_o
);

  // input register
  logic                              r_valid_q;
  logic [lfrd_pkg::READING_W-1:0]    r_reading_q;
  logic                              r_last_q;

  // scan state
  logic [CW-1:0]                     cnt_q, cnt_d;
  logic [CW-1:0]                     quo_q, quo_d;
  logic [lfrd_pkg::BAND_REM_W-1:0]   rem_q, rem_d;
  logic                              in_run_q, in_run_d;
  logic [SW-1:0]                     run_start_q, run_start_d;
  logic [CW-1:0]                     run_len_q, run_len_d;
  logic [SW-1:0]                     best_start_q, best_start_d;
  logic [CW-1:0]                     best_len_q, best_len_d;

  // closed scan register
  logic                              fin_valid_q;
  logic [CW-1:0]                     fin_count_q;
  logic [CW-1:0]                     fin_band_q;
  logic [CW-1:0]                     fin_len_q;
  logic [SW-1:0]                     fin_start_q;

  logic                              fin_ready;
  logic                              go;
  logic                              take;
  logic                              occupied;
  logic                              match;
  logic [SW-1:0]                     close_start;
  logic [CW-1:0]                     close_len;

  assign fin_ready   = !fin_valid_q || fin_take_i;
  assign go          = r_valid_q && (!r_last_q || fin_ready);
  assign in_ch.ready = !r_valid_q || go;

  // input register load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else begin
      r_valid_q <= (r_valid_q && !go) || (in_ch.valid && in_ch.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      r_reading_q <= in_ch.reading;
      r_last_q    <= in_ch.last_sector;
    end
  end

  // classify the sector and extend or close the current run
  always_comb begin
    take         = cnt_q < CW'(MAX_SECTORS);
    occupied     = r_reading_q > near_threshold_i;
    match        = seek_occupied_i ? occupied : !occupied;
    cnt_d        = cnt_q;
    quo_d        = quo_q;
    rem_d        = rem_q;
    in_run_d     = in_run_q;
    run_start_d  = run_start_q;
    run_len_d    = run_len_q;
    best_start_d = best_start_q;
    best_len_d   = best_len_q;
    if (take) begin
      if (match) begin
        if (in_run_q) begin
          run_len_d = run_len_q + CW'(1);
        end else begin
          in_run_d    = 1'b1;
          run_start_d = cnt_q[SW-1:0];
          run_len_d   = CW'(1);
        end
      end else begin
        if (in_run_q && (run_len_q > best_len_q)) begin
          best_len_d   = run_len_q;
          best_start_d = run_start_q;
        end
        in_run_d = 1'b0;
      end
      cnt_d = cnt_q + CW'(1);
      // running count / 10
      if (rem_q == lfrd_pkg::BAND_REM_W'(lfrd_pkg::BAND_DIV - 1)) begin
        rem_d = '0;
        quo_d = quo_q + CW'(1);
      end else begin
        rem_d = rem_q + lfrd_pkg::BAND_REM_W'(1);
      end
    end
  end

  // close the run still open at the end of the scan
  always_comb begin
    close_start = best_start_d;
    close_len   = best_len_d;
    if (in_run_d && (run_len_d > best_len_d)) begin
      close_start = run_start_d;
      close_len   = run_len_d;
    end
  end

  // scan state update, cleared after the last sector
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      quo_q        <= '0;
      rem_q        <= '0;
      in_run_q     <= 1'b0;
      run_start_q  <= '0;
      run_len_q    <= '0;
      best_start_q <= '0;
      best_len_q   <= '0;
    end else if (go) begin
      if (r_last_q) begin
        cnt_q        <= '0;
        quo_q        <= '0;
        rem_q        <= '0;
        in_run_q     <= 1'b0;
        run_start_q  <= '0;
        run_len_q    <= '0;
        best_start_q <= '0;
        best_len_q   <= '0;
      end else begin
        cnt_q        <= cnt_d;
        quo_q        <= quo_d;
        rem_q        <= rem_d;
        in_run_q     <= in_run_d;
        run_start_q  <= run_start_d;
        run_len_q    <= run_len_d;
        best_start_q <= best_start_d;
        best_len_q   <= best_len_d;
      end
    end
  end

  // closed scan handoff
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else begin
      fin_valid_q <= (fin_valid_q && !fin_take_i) || (go && r_last_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && r_last_q) begin
      fin_count_q <= cnt_d;
      fin_band_q  <= quo_d;
      fin_len_q   <= close_len;
      fin_start_q <= close_start;
    end
  end

  assign fin_valid_o = fin_valid_q;
  assign fin_count_o = fin_count_q;
  assign fin_band_o  = fin_band_q;
  assign fin_len_o   = fin_len_q;
  assign fin_start_o = fin_start_q;

endmodule

// ===== rtl/longest_free_run_direction.sv =====
// Longest free run direction: finds the longest run of free (or occupied)
// sectors in one locator scan and the direction toward its centre.
//
// Channels: in_ch takes one range reading per transaction, last_sector marks
// the end of a scan. out_ch gives one result per scan (direction, centre,
// run_weight). cfg_ch writes near_threshold (index 0) and seek_occupied
// (index 1); it is always ready and should be used only while the block idles.
// Throughput: one sector per cycle, back to back, with no gaps between scans,
// as long as no last sector has to wait for a free closed-scan register.
// A last sector passes the input register, then the run tracker's closed-scan
// register, then the result register with centre and direction, where its
// result becomes valid on out_ch.
// Reset clears the scan state, both configuration registers and all valid flags.
// When the result receiver stalls, one finished scan waits in the result
// register and one more in the closed-scan register; sectors of the next scan
// keep flowing until a further last sector finds both full, then in_ch stalls.
// depends on lfrd_pkg, lfrd_in_if, lfrd_out_if, lfrd_cfg_if, lfrd_tracker
module longest_free_run_direction #(
  parameter int unsigned MAX_SECTORS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lfrd_in_if.sink     in_ch,
  lfrd_out_if.source  out_ch,
  lfrd_cfg_if.sink    cfg_ch
);

  localparam int unsigned CW = $clog2(MAX_SECTORS + 1);
  localparam int unsigned SW = $clog2(MAX_SECTORS);
  localparam int unsigned XW = (CW > lfrd_pkg::WEIGHT_W) ? CW : lfrd_pkg::WEIGHT_W;

  // configuration registers
  logic [lfrd_pkg::READING_W-1:0]    near_threshold_q;
  logic                              seek_occupied_q;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_threshold_q <= '0;
      seek_occupied_q  <= 1'b0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        lfrd_pkg::REG_NEAR_THRESHOLD: near_threshold_q <= cfg_ch.data;
        lfrd_pkg::REG_SEEK_OCCUPIED:  seek_occupied_q  <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // run tracking
  logic                              fin_valid;
  logic                              fin_take;
  logic [CW-1:0]                     fin_count;
  logic [CW-1:0]                     fin_band;
  logic [CW-1:0]                     fin_len;
  logic [SW-1:0]                     fin_start;

  lfrd_tracker #(
    .MAX_SECTORS (MAX_SECTORS),
    .CW          (CW),
    .SW          (SW)
  ) u_tracker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_ch            (in_ch),
    .near_threshold_i (near_threshold_q),
    .seek_occupied_i  (seek_occupied_q),
    .fin_take_i       (fin_take),
    .fin_valid_o      (fin_valid),
    .fin_count_o      (fin_count),
    .fin_band_o       (fin_band),
    .fin_len_o        (fin_len),
    .fin_start_o      (fin_start)
  );

  // centre and direction of the closed scan
  logic [CW:0]                       centre_w;
  logic [CW:0]                       mid_w;
  logic [CW:0]                       band_w;
  logic [XW-1:0]                     centre_x;
  logic [XW-1:0]                     weight_x;
  lfrd_pkg::dir_e                    dir_d;

  always_comb begin
    centre_w = (CW+1)'(fin_start) + (CW+1)'(fin_len >> 1);
    mid_w    = (CW+1)'(fin_count >> 1);
    band_w   = (CW+1)'(fin_band);
    dir_d    = lfrd_pkg::DIR_FWD;
    if ((centre_w + band_w) < mid_w) begin
      dir_d = lfrd_pkg::DIR_LEFT;
    end
    if (centre_w > (mid_w + band_w)) begin
      dir_d = lfrd_pkg::DIR_RIGHT;
    end
    if (fin_len == '0) begin
      dir_d    = lfrd_pkg::DIR_NONE;
      centre_w = '0;
    end
    centre_x = XW'(centre_w);
    weight_x = XW'(fin_len);
  end

  // result register
  logic                              out_valid_q;
  lfrd_pkg::dir_e                    out_dir_q;
  logic [lfrd_pkg::CENTRE_W-1:0]     out_centre_q;
  logic [lfrd_pkg::WEIGHT_W-1:0]     out_weight_q;

  assign fin_take = fin_valid && (!out_valid_q || out_ch.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (out_valid_q && !out_ch.ready) || fin_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_take) begin
      out_dir_q    <= dir_d;
      out_centre_q <= centre_x[lfrd_pkg::CENTRE_W-1:0];
      out_weight_q <= weight_x[lfrd_pkg::WEIGHT_W-1:0];
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.direction  = out_dir_q;
  assign out_ch.centre     = out_centre_q;
  assign out_ch.run_weight = out_weight_q;

endmodule

// ===== bench/testbench.sv =====
// testbench: self-checking bench for the longest free run direction block
// predicts each scan result from the sector stream and compares every field
// depends on lfrd_pkg, lfrd_in_if, lfrd_out_if, lfrd_cfg_if, longest_free_run_direction
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_SECTORS  = 256;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned SETTLE_TIME  = 8;
  localparam int unsigned RAND_PHASES  = 9;
  localparam int unsigned PHASE_ITEMS  = 20;
  localparam int unsigned PHASE_SCANS  = 3;

  typedef struct packed {
    logic [lfrd_pkg::READING_W-1:0] reading;
    logic                           last_sector;
  } sector_t;

  typedef struct packed {
    lfrd_pkg::dir_e                direction;
    logic [lfrd_pkg::CENTRE_W-1:0] centre;
    logic [lfrd_pkg::WEIGHT_W-1:0] run_weight;
  } run_result_t;

  logic clk_i;
  logic rst_ni;

  lfrd_in_if  in_ch ();
  lfrd_out_if out_ch ();
  lfrd_cfg_if cfg_ch ();

  longest_free_run_direction #(
    .MAX_SECTORS(MAX_SECTORS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // stimulus and expectation stores
  sector_t     pending_sectors[$];
  run_result_t expected_runs[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned error_count   = 0;
  int unsigned stall_cycles  = 0;

  // predictor configuration, mirrors the register writes
  logic [lfrd_pkg::CFG_DAT_W-1:0] cfg_threshold     = '0;
  logic                           cfg_seek_occupied = 1'b0;

  // predictor scan state
  logic [lfrd_pkg::WEIGHT_W-1:0]  scan_sectors   = '0;
  logic                           scan_in_run    = 1'b0;
  logic [lfrd_pkg::CENTRE_W-1:0]  cur_run_start  = '0;
  logic [lfrd_pkg::WEIGHT_W-1:0]  cur_run_len    = '0;
  logic [lfrd_pkg::CENTRE_W-1:0]  best_run_start = '0;
  logic [lfrd_pkg::WEIGHT_W-1:0]  best_run_len   = '0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // a finished run replaces the best one only when strictly longer
  task automatic close_run();
    if (scan_in_run && cur_run_len > best_run_len) begin
      best_run_len   = cur_run_len;
      best_run_start = cur_run_start;
    end
    scan_in_run = 1'b0;
  endtask

  // run tracking for one accepted sector, queues the scan result on the last one
  task automatic track_sector(input logic [lfrd_pkg::READING_W-1:0] reading,
                              input logic last);
    logic        hit;
    int unsigned ctr;
    int unsigned mid;
    int unsigned band;
    run_result_t res;
    if (scan_sectors < MAX_SECTORS) begin
      hit = ((reading > cfg_threshold) == cfg_seek_occupied);
      if (hit) begin
        if (scan_in_run) begin
          cur_run_len++;
        end else begin
          scan_in_run   = 1'b1;
          cur_run_start = scan_sectors[lfrd_pkg::CENTRE_W-1:0];
          cur_run_len   = lfrd_pkg::WEIGHT_W'(1);
        end
      end else begin
        close_run();
      end
      scan_sectors++;
    end
    if (last) begin
      close_run();
      ctr  = 32'(best_run_start) + 32'(best_run_len) / 2;
      mid  = 32'(scan_sectors) / 2;
      band = 32'(scan_sectors) / lfrd_pkg::BAND_DIV;
      res.direction = lfrd_pkg::DIR_FWD;
      if (ctr + band < mid) res.direction = lfrd_pkg::DIR_LEFT;
      if (ctr > mid + band) res.direction = lfrd_pkg::DIR_RIGHT;
      if (best_run_len == '0) begin
        res.direction = lfrd_pkg::DIR_NONE;
        ctr = 0;
      end
      res.centre     = ctr[lfrd_pkg::CENTRE_W-1:0];
      res.run_weight = best_run_len;
      expected_runs.insert(expected_runs.size(), res);
      scan_sectors   = '0;
      scan_in_run    = 1'b0;
      cur_run_start  = '0;
      cur_run_len    = '0;
      best_run_start = '0;
      best_run_len   = '0;
    end
  endtask

  // sector driver: holds a transaction until accepted, then takes the next one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid       <= 1'b0;
      in_ch.reading     <= '0;
      in_ch.last_sector <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        track_sector(in_ch.reading, in_ch.last_sector);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_sectors.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          sector_t nxt;
          nxt = pending_sectors.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.reading     <= nxt.reading;
          in_ch.last_sector <= nxt.last_sector;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_runs.size() == 0) begin
          report_error($sformatf("result with nothing expected: dir %0d centre %0d weight %0d",
                                 out_ch.direction, out_ch.centre, out_ch.run_weight));
        end else begin
          run_result_t want;
          want = expected_runs.pop_front();
          if (out_ch.direction !== want.direction)
            report_error($sformatf("direction %0d, expected %0d",
                                   out_ch.direction, want.direction));
          if (out_ch.centre !== want.centre)
            report_error($sformatf("centre %0d, expected %0d", out_ch.centre, want.centre));
          if (out_ch.run_weight !== want.run_weight)
            report_error($sformatf("run_weight %0d, expected %0d",
                                   out_ch.run_weight, want.run_weight));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= '0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one register write over the configuration channel
  task automatic write_reg(input lfrd_pkg::reg_idx_e idx,
                           input logic [lfrd_pkg::CFG_DAT_W-1:0] value);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    if (idx == lfrd_pkg::REG_NEAR_THRESHOLD) cfg_threshold = value;
    else if (idx == lfrd_pkg::REG_SEEK_OCCUPIED) cfg_seek_occupied = value[0];
    cfg_ch.valid <= 1'b0;
  endtask

  // wait for every sector taken and every result seen, then let the pipe settle
  task automatic wait_drained();
    while (pending_sectors.size() != 0 || in_ch.valid || expected_runs.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_TIME) @(posedge clk_i);
  endtask

  task automatic add_sector(input logic [lfrd_pkg::READING_W-1:0] reading, input logic last);
    sector_t s;
    s.reading     = reading;
    s.last_sector = last;
    pending_sectors.insert(pending_sectors.size(), s);
  endtask

  // a reading on the wanted side of the threshold
  function automatic logic [lfrd_pkg::READING_W-1:0] pick_reading(input logic want_occupied);
    if (want_occupied && cfg_threshold != 8'hFF)
      return lfrd_pkg::READING_W'($urandom_range(255, int'(cfg_threshold) + 1));
    else if (!want_occupied)
      return lfrd_pkg::READING_W'($urandom_range(int'(cfg_threshold), 0));
    return lfrd_pkg::READING_W'($urandom_range(255, 0));
  endfunction

  // one scan built from alternating matching and non-matching segments
  task automatic add_scan(input int unsigned len);
    int unsigned idx;
    int unsigned seg;
    logic        seg_hit;
    logic [lfrd_pkg::READING_W-1:0] rd;
    idx     = 0;
    seg_hit = 1'($urandom_range(1));
    while (idx < len) begin
      seg = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      for (int unsigned k = 0; k < seg && idx < len; k++) begin
        if ($urandom_range(99) < 8) rd = lfrd_pkg::READING_W'($urandom_range(255));
        else rd = pick_reading(cfg_seek_occupied ? seg_hit : !seg_hit);
        add_sector(rd, idx == len - 1);
        idx++;
      end
      seg_hit = !seg_hit;
    end
  endtask

  // mostly short scans and a few longer ones
  function automatic int unsigned pick_scan_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 95) return $urandom_range(16, 1);
    return $urandom_range(48, 17);
  endfunction

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin
        send_idle_pct = 14;
        recv_idle_pct = 84;
      end
      1: begin
        send_idle_pct = 84;
        recv_idle_pct = 14;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // main sequence
  initial begin
    int unsigned   phase_items;
    int unsigned   phase_scans;
    int unsigned   len;
    logic [lfrd_pkg::CFG_DAT_W-1:0] thr;
    logic          seek;

    rst_ni            = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.reading     = '0;
    in_ch.last_sector = 1'b0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = lfrd_pkg::REG_NEAR_THRESHOLD;
    cfg_ch.data       = '0;
    set_idling(0);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed scans at reset settings: only a zero reading is free
    add_sector(8'd0, 1'b1);                           // single free sector, forward
    add_sector(8'd255, 1'b1);                         // nothing free, none
    for (int i = 0; i < 8; i++)                       // run at the start, left
      add_sector((i < 2) ? 8'd0 : 8'd5, i == 7);
    for (int i = 0; i < 8; i++)                       // run at the end, right
      add_sector((i >= 6) ? 8'd0 : 8'd5, i == 7);
    add_sector(8'd0, 1'b0);                           // tie, first run kept
    add_sector(8'd0, 1'b0);
    add_sector(8'd7, 1'b0);
    add_sector(8'd0, 1'b0);
    add_sector(8'd0, 1'b0);
    add_sector(8'd7, 1'b1);
    wait_drained();

    // random phases over several register settings
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin thr = 8'hFF; seek = 1'b0; end
        1: begin thr = 8'h00; seek = 1'b1; end
        2: begin thr = 8'hFF; seek = 1'b1; end
        3: begin thr = 8'h00; seek = 1'b0; end
        default: begin
          thr  = lfrd_pkg::CFG_DAT_W'($urandom_range(255));
          seek = 1'($urandom_range(1));
        end
      endcase
      set_idling(ph / 3);
      write_reg(lfrd_pkg::REG_NEAR_THRESHOLD, thr);
      write_reg(lfrd_pkg::REG_SEEK_OCCUPIED, {7'($urandom_range(127)), seek});
      phase_items = 0;
      phase_scans = 0;
      if (ph == 0) begin
        // every sector free: a full scan that runs past the sector limit
        add_scan(MAX_SECTORS + 4);
      end
      while (phase_items < PHASE_ITEMS || phase_scans < PHASE_SCANS) begin
        len = pick_scan_len();
        add_scan(len);
        phase_items += len;
        phase_scans++;
      end
      wait_drained();
    end

    if (expected_runs.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_runs.size()));
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lfrd_pkg.sv
rtl/lfrd_in_if.sv
rtl/lfrd_out_if.sv
rtl/lfrd_cfg_if.sv
rtl/lfrd_tracker.sv
rtl/longest_free_run_direction.sv
bench/testbench.sv
